// ===== hw/rtl/rfs_pkg.sv =====
`timescale 1ns / 1ps
package rfs_pkg;

  localparam int MOVEOUT_SHIFT = 24;
  localparam logic [64:0] MO_LIMIT = 65'd1 << 42;

  localparam logic [2:0] CFG_MODE          = 3'd0;
  localparam logic [2:0] CFG_INTERPOLATE   = 3'd1;
  localparam logic [2:0] CFG_ANGLE_FACTOR  = 3'd2;
  localparam logic [2:0] CFG_INV_DT        = 3'd3;
  localparam logic [2:0] CFG_AMP_THRESHOLD = 3'd4;
  localparam logic [2:0] CFG_TRACE_LENGTH  = 3'd5;
  localparam logic [2:0] CFG_DATA_LIMIT    = 3'd6;
  localparam logic [2:0] CFG_MODEL_LIMIT   = 3'd7;

  localparam logic [1:0] MODE_HYPERBOLIC = 2'd0;
  localparam logic [1:0] MODE_PARABOLIC  = 2'd1;

  localparam logic OP_SPREAD = 1'b0;
  localparam logic OP_READ   = 1'b1;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_M1, S_M2, S_M3, S_MO, S_TSQ, S_T2, S_SQRT, S_LIN,
    S_ITQ1, S_ITQ2, S_ITQ3, S_INDEX, S_CHECK, S_W1, S_RD0, S_WR0, S_RD1,
    S_WR1, S_RREAD, S_RWRITE, S_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic done;
  } sqrt_ctl_t;

endpackage

// ===== hw/rtl/rfs_if.sv =====
`timescale 1ns / 1ps
interface rfs_in_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic signed [23:0] amplitude;
  logic [23:0]        tau_time;
  logic signed [31:0] curvature;
  logic signed [15:0] offset;
  logic [5:0]         offset_index;
  logic [15:0]        model_index;
  logic [15:0]        read_index;
  modport source (output valid, operation, amplitude, tau_time, curvature, offset,
                  offset_index, model_index, read_index, input ready);
  modport sink (input valid, operation, amplitude, tau_time, curvature, offset,
                offset_index, model_index, read_index, output ready);
endinterface

interface rfs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] read_value;
  modport source (output valid, read_value, input ready);
  modport sink (input valid, read_value, output ready);
endinterface

// ===== hw/rtl/radon_forward_spread_core.sv =====
`timescale 1ns / 1ps
// channel  dir  handshake      payload
// in_ch    in   valid/ready    operation, amplitude, tau_time, curvature, offset,
//                              offset_index, model_index, read_index
// out_ch   out  valid/ready    read_value
// cfg      in   cfg_we         cfg_index, cfg_data
//
// one item at a time; a hyperbolic spread runs the 32-step bit-serial square root
// after reset the store is zeroed one entry a cycle, all TRACES*TRACE_SAMPLES entries,
// with in_ch.ready low; configuration writes are taken throughout
// a result waits in the output register while the next item is accepted
module radon_forward_spread_core #(
  parameter int TRACES        = 64,
  parameter int TRACE_SAMPLES = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  rfs_in_if.sink      in_ch,
  rfs_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  localparam int DEPTH = TRACES * TRACE_SAMPLES;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [42:0] DEPTH_W = 43'(DEPTH);

  rfs_pkg::state_t state_r, state_nxt;

  logic [1:0]  mode_r;
  logic        interp_r;
  logic [15:0] angle_r;
  logic [31:0] inv_dt_r;
  logic [22:0] thr_r;
  logic [10:0] tl_r;
  logic [16:0] dl_r;
  logic [16:0] ml_r;

  logic signed [23:0] amp_r;
  logic [23:0] tau_r;
  logic [31:0] qm_r;
  logic [15:0] hm_r;
  logic        neg_r;
  logic [5:0]  oidx_r;
  logic [15:0] ridx_r;
  logic [31:0] p1_r;
  logic [32:0] a_r;
  logic [64:0] mag_r;
  logic signed [43:0] mo_r;
  logic [47:0] tsq_r;
  logic [43:0] time_r;
  logic [55:0] pa_r;
  logic [31:0] pb_r;
  logic [56:0] itq_r;
  logic [41:0] j_r;
  logic signed [24:0] add0_r;
  logic signed [24:0] add1_r;
  logic [31:0] hold_r;
  logic [AW-1:0] clr_r;
  logic        out_valid_r;
  logic [31:0] out_data_r;

  logic [23:0] amag;
  logic        skip;
  logic        in_acc;
  logic [64:0] magsh;
  logic [64:0] magc;
  logic signed [65:0] t2s;
  logic signed [44:0] lin;
  logic [51:0] fprod;
  logic        edge_hit;
  logic [42:0] j1;
  logic        range_ok;
  logic        rrange;
  logic [AW+15:0] ridx_ext;
  logic        slot_free;
  logic signed [41:0] prod0;
  logic signed [41:0] prod1;
  logic signed [32:0] sum;
  logic [31:0] sat;
  logic        ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0] ram_wdata, ram_rdata;
  logic [31:0] root;
  rfs_pkg::sqrt_ctl_t sq_in, sq_out;

  assign amag   = in_ch.amplitude[23] ? 24'(-in_ch.amplitude) : 24'(in_ch.amplitude);
  assign skip   = ({1'b0, amag} <= {2'b00, thr_r}) || ({1'b0, in_ch.model_index} >= ml_r);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign slot_free = !out_valid_r || out_ch.ready;

  assign magsh = mag_r >> rfs_pkg::MOVEOUT_SHIFT;
  always_comb begin
    magc = magsh + {64'd0, neg_r && ((mag_r & ((65'd1 << rfs_pkg::MOVEOUT_SHIFT) - 65'd1))
                                      != 65'd0)};
    if (magc > rfs_pkg::MO_LIMIT) begin
      magc = rfs_pkg::MO_LIMIT;
    end
  end

  assign t2s = $signed({18'd0, tsq_r}) + 66'($signed({mo_r, 20'd0}));
  assign lin = $signed({21'd0, tau_r}) + 45'(mo_r);
  assign fprod = time_r[19:0] * inv_dt_r;
  assign edge_hit = itq_r == {30'd0, tl_r, 16'd0};
  assign j1 = {1'b0, j_r} + 43'd1;
  assign range_ok = interp_r ? (j1 < {26'd0, dl_r}) && (j1 < DEPTH_W)
                             : ({1'b0, j_r} < {26'd0, dl_r}) && ({1'b0, j_r} < DEPTH_W);
  assign rrange = {27'd0, ridx_r} < DEPTH_W;
  assign ridx_ext = {{AW{1'b0}}, ridx_r};
  assign prod0 = amp_r * $signed({1'b0, 17'd65536 - {1'b0, itq_r[15:0]}});
  assign prod1 = amp_r * $signed({2'b00, itq_r[15:0]});

  always_comb begin
    sum = {ram_rdata[31], ram_rdata} +
          ((state_r == rfs_pkg::S_WR1) ? 33'(add1_r) : 33'(add0_r));
    if (sum > 33'sd2147483647) begin
      sat = 32'h7FFF_FFFF;
    end else if (sum < -33'sd2147483648) begin
      sat = 32'h8000_0000;
    end else begin
      sat = sum[31:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rfs_pkg::S_CLEAR:  if (clr_r == AW'(DEPTH - 1)) state_nxt = rfs_pkg::S_IDLE;
      rfs_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_ch.operation == rfs_pkg::OP_READ) state_nxt = rfs_pkg::S_RREAD;
          else if (!skip) state_nxt = rfs_pkg::S_M1;
        end
      end
      rfs_pkg::S_M1:     state_nxt = rfs_pkg::S_M2;
      rfs_pkg::S_M2:     state_nxt = rfs_pkg::S_M3;
      rfs_pkg::S_M3:     state_nxt = rfs_pkg::S_MO;
      rfs_pkg::S_MO:     state_nxt = (mode_r == rfs_pkg::MODE_HYPERBOLIC) ? rfs_pkg::S_TSQ
                                                                        : rfs_pkg::S_LIN;
      rfs_pkg::S_TSQ:    state_nxt = rfs_pkg::S_T2;
      rfs_pkg::S_T2:     state_nxt = t2s[65] ? rfs_pkg::S_IDLE : rfs_pkg::S_SQRT;
      rfs_pkg::S_SQRT:   if (sq_out.done) state_nxt = rfs_pkg::S_ITQ1;
      rfs_pkg::S_LIN:    state_nxt = lin[44] ? rfs_pkg::S_IDLE : rfs_pkg::S_ITQ1;
      rfs_pkg::S_ITQ1:   state_nxt = rfs_pkg::S_ITQ2;
      rfs_pkg::S_ITQ2:   state_nxt = rfs_pkg::S_ITQ3;
      rfs_pkg::S_ITQ3:   state_nxt = rfs_pkg::S_INDEX;
      rfs_pkg::S_INDEX:  state_nxt = edge_hit ? rfs_pkg::S_IDLE : rfs_pkg::S_CHECK;
      rfs_pkg::S_CHECK:  state_nxt = !range_ok ? rfs_pkg::S_IDLE
                                   : (interp_r ? rfs_pkg::S_W1 : rfs_pkg::S_RD0);
      rfs_pkg::S_W1:     state_nxt = rfs_pkg::S_RD0;
      rfs_pkg::S_RD0:    state_nxt = rfs_pkg::S_WR0;
      rfs_pkg::S_WR0:    state_nxt = interp_r ? rfs_pkg::S_RD1 : rfs_pkg::S_IDLE;
      rfs_pkg::S_RD1:    state_nxt = rfs_pkg::S_WR1;
      rfs_pkg::S_WR1:    state_nxt = rfs_pkg::S_IDLE;
      rfs_pkg::S_RREAD:  state_nxt = rfs_pkg::S_RWRITE;
      rfs_pkg::S_RWRITE: state_nxt = rfs_pkg::S_OUT;
      rfs_pkg::S_OUT:    if (slot_free) state_nxt = rfs_pkg::S_IDLE;
      default:           state_nxt = rfs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state_r == rfs_pkg::S_IDLE);
    ram_we      = 1'b0;
    ram_waddr   = j_r[AW-1:0];
    ram_wdata   = sat;
    ram_raddr   = j_r[AW-1:0];
    sq_in.start = (state_r == rfs_pkg::S_T2) && !t2s[65];
    sq_in.done  = 1'b0;
    unique case (state_r)
      rfs_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
      end
      rfs_pkg::S_WR0:   ram_we = 1'b1;
      rfs_pkg::S_RD1:   ram_raddr = j1[AW-1:0];
      rfs_pkg::S_WR1: begin
        ram_we    = 1'b1;
        ram_waddr = j1[AW-1:0];
      end
      rfs_pkg::S_RREAD: ram_raddr = ridx_ext[AW-1:0];
      rfs_pkg::S_RWRITE: begin
        ram_we    = rrange;
        ram_waddr = ridx_ext[AW-1:0];
        ram_wdata = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rfs_pkg::S_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      mode_r      <= 2'd0;
      interp_r    <= 1'b1;
      angle_r     <= 16'd32768;
      inv_dt_r    <= 32'd16384000;
      thr_r       <= 23'd655;
      tl_r        <= 11'd1024;
      dl_r        <= 17'd65536;
      ml_r        <= 17'd65536;
    end else begin
      state_r <= state_nxt;
      if (state_r == rfs_pkg::S_CLEAR) clr_r <= clr_r + AW'(1);
      if (state_r == rfs_pkg::S_OUT && slot_free) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          rfs_pkg::CFG_MODE:          mode_r   <= cfg_data[1:0];
          rfs_pkg::CFG_INTERPOLATE:   interp_r <= cfg_data[0];
          rfs_pkg::CFG_ANGLE_FACTOR:  angle_r  <= cfg_data[15:0];
          rfs_pkg::CFG_INV_DT:        inv_dt_r <= cfg_data;
          rfs_pkg::CFG_AMP_THRESHOLD: thr_r    <= cfg_data[22:0];
          rfs_pkg::CFG_TRACE_LENGTH:  tl_r     <= cfg_data[10:0];
          rfs_pkg::CFG_DATA_LIMIT:    dl_r     <= cfg_data[16:0];
          default:                    ml_r     <= cfg_data[16:0];
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      amp_r  <= in_ch.amplitude;
      tau_r  <= in_ch.tau_time;
      qm_r   <= in_ch.curvature[31] ? 32'(-in_ch.curvature) : 32'(in_ch.curvature);
      hm_r   <= in_ch.offset[15] ? 16'(-in_ch.offset) : 16'(in_ch.offset);
      neg_r  <= (mode_r == rfs_pkg::MODE_HYPERBOLIC || mode_r == rfs_pkg::MODE_PARABOLIC)
                ? in_ch.curvature[31] : (in_ch.curvature[31] ^ in_ch.offset[15]);
      oidx_r <= in_ch.offset_index;
      ridx_r <= in_ch.read_index;
    end
    case (state_r)
      rfs_pkg::S_M1:  p1_r <= hm_r * hm_r;
      rfs_pkg::S_M2: begin
        if (mode_r == rfs_pkg::MODE_HYPERBOLIC) a_r <= 33'((48'(p1_r) * angle_r) >> 15);
        else if (mode_r == rfs_pkg::MODE_PARABOLIC) a_r <= {1'b0, p1_r};
        else a_r <= {17'd0, hm_r};
      end
      rfs_pkg::S_M3:  mag_r <= qm_r * a_r;
      rfs_pkg::S_MO:  mo_r <= neg_r ? -$signed(magc[43:0]) : $signed(magc[43:0]);
      rfs_pkg::S_TSQ: tsq_r <= tau_r * tau_r;
      rfs_pkg::S_SQRT: if (sq_out.done) time_r <= {12'd0, root};
      rfs_pkg::S_LIN: time_r <= lin[43:0];
      rfs_pkg::S_ITQ1: pa_r <= time_r[43:20] * inv_dt_r;
      rfs_pkg::S_ITQ2: pb_r <= fprod[51:20];
      rfs_pkg::S_ITQ3: itq_r <= {1'b0, pa_r} + {25'd0, pb_r};
      rfs_pkg::S_INDEX: j_r <= 42'(oidx_r) * 42'(tl_r) + {1'b0, itq_r[56:16]};
      rfs_pkg::S_CHECK: begin
        add0_r <= interp_r ? 25'((prod0 + 42'sd32768) >>> 16) : 25'(amp_r);
      end
      rfs_pkg::S_W1:  add1_r <= 25'((prod1 + 42'sd32768) >>> 16);
      rfs_pkg::S_RWRITE: hold_r <= rrange ? ram_rdata : 32'd0;
      rfs_pkg::S_OUT: if (slot_free) out_data_r <= hold_r;
      default: ;
    endcase
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_data_r;

  rfs_isqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (t2s[63:0]),
    .ctl_in  (sq_in),
    .ctl_out (sq_out),
    .root    (root)
  );

  rfs_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rfs_pkg::S_CLEAR) |-> !in_ch.ready) else $error("item taken during clear");
  a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == rfs_pkg::S_OUT)) else $error("stray result");
  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == rfs_pkg::S_CLEAR || state_r == rfs_pkg::S_WR0 ||
                state_r == rfs_pkg::S_WR1 || state_r == rfs_pkg::S_RWRITE))
    else $error("store write outside update");
  a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == rfs_pkg::S_RWRITE && ram_we) |-> ram_wdata == 32'd0)
    else $error("read did not clear entry");
endmodule

// ===== hw/rtl/rfs_ram.sv =====
`timescale 1ns / 1ps
module rfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hw/rtl/rfs_isqrt.sv =====
`timescale 1ns / 1ps
module rfs_isqrt (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [63:0]       op,
  input  rfs_pkg::sqrt_ctl_t ctl_in,
  output rfs_pkg::sqrt_ctl_t ctl_out,
  output logic [31:0]       root
);
  logic [63:0] val_r;
  logic [35:0] rem_r;
  logic [31:0] root_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [35:0] rem_sh;
  logic [35:0] trial;

  assign rem_sh = {rem_r[33:0], val_r[63:62]};
  assign trial  = {2'b00, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl_in.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.start) begin
      val_r  <= op;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      val_r <= {val_r[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_r  <= rem_sh - trial;
        root_r <= {root_r[30:0], 1'b1};
      end else begin
        rem_r  <= rem_sh;
        root_r <= {root_r[30:0], 1'b0};
      end
    end
  end

  assign ctl_out.start = busy_r;
  assign ctl_out.done  = done_r;
  assign root = root_r;

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("sqrt done without run");
endmodule
